// ----- rtl/svbs_pkg.sv -----
// Shared types, codes and constants of the SDF voxel brick sampler.
package svbs_pkg;

    localparam int VOX_W     = 10;
    localparam int VSIZE_W   = 21;
    localparam int GDIM_W    = 11;
    localparam int DIST_W    = 27;
    localparam int CFG_W     = 21;
    localparam int CFG_IDX_W = 2;

    localparam logic [GDIM_W-1:0]  MAX_GRID_DIMS  = 11'd1024;
    localparam logic [VSIZE_W-1:0] VSIZE_RESET    = 21'd65536;
    localparam logic [GDIM_W-1:0]  GDIM_RESET     = 11'd128;
    localparam logic signed [33:0] BG_Q16         = 34'sd65536000;
    // ceil(2^26 / 5): x*R >> 26 is x / 5 and x*R >> 27 is x / 10 for x below 2^26
    localparam logic [23:0]        RECIP_DIV5         = 24'd13421773;
    localparam int                 RECIP_SHIFT_SPHERE = 26;
    localparam int                 RECIP_SHIFT_BOX    = 27;
    localparam logic [4:0]         ROOT_LAST_STEP = 5'd31;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHAPE = 2'd0,
        CFG_VSIZE = 2'd1,
        CFG_GDIM  = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        SHAPE_SPHERE = 1'b0,
        SHAPE_BOX    = 1'b1
    } t_shape;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AXIS,
        S_EXT,
        S_SQ,
        S_ROOT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [VOX_W-1:0] voxel_x;
        logic [VOX_W-1:0] voxel_y;
        logic [VOX_W-1:0] voxel_z;
        logic             brick_last;
    } t_voxel;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance_q16;
        logic                     brick_end;
        logic                     brick_active;
    } t_sample;

endpackage

// ----- rtl/svbs_voxel_if.sv -----
// Voxel index channel: valid, ready and one voxel item.
interface svbs_voxel_if;
    logic                valid;
    logic                ready;
    svbs_pkg::t_voxel    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/svbs_sample_if.sv -----
// Distance sample channel: valid, ready and one sample item.
interface svbs_sample_if;
    logic                valid;
    logic                ready;
    svbs_pkg::t_sample   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/sdf_voxel_brick_sampler_unit.sv -----
// Top level of the SDF voxel brick sampler: sequencer, shared multiplier, square root.
//
//   channel   dir   handshake          payload
//   i_vox     in    valid / ready      voxel_x, voxel_y, voxel_z, brick_last
//   o_smp     out   valid / ready      distance_q16, brick_end, brick_active
//   i_cfg_*   in    write enable only  index 0..2, 21-bit data
//
// The block takes one item at a time; it is ready again once the sample of the last
// item is in the output register. The axis, radius or half-extent and square steps
// share one multiplier and come before the 32-step square root. Reset clears the
// registers to sphere, 1 mm voxels and 128 voxels per axis. A stalled sample holds
// in the output register; the block still takes the next item and waits before its
// own result if the earlier one is still not taken.
module sdf_voxel_brick_sampler_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    svbs_voxel_if.sink                          i_vox,
    svbs_sample_if.source                       o_smp,
    input  logic                                i_cfg_we,
    input  logic [svbs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [svbs_pkg::CFG_W-1:0]          i_cfg_data
);

    // configuration
    logic                              r_shape;
    logic [svbs_pkg::VSIZE_W-1:0]      r_vsize;
    logic [svbs_pkg::GDIM_W-1:0]       r_gdim;

    // sequencer
    svbs_pkg::t_state                  r_state;
    svbs_pkg::t_state                  n_state;
    logic [5:0]                        r_cnt;
    logic [5:0]                        n_cnt;

    // datapath
    svbs_pkg::t_voxel                  r_vox;
    logic [30:0]                       r_a [3];
    logic [30:0]                       r_dq;
    logic [9:0]                        r_qn;
    logic [24:0]                       r_part;
    logic [63:0]                       r_prod;
    logic [63:0]                       r_sum;
    logic signed [31:0]                r_qmax;
    logic                              r_saw;

    // output register
    logic                              r_ovalid;
    svbs_pkg::t_sample                 r_out;

    logic                              vox_xfer;
    logic                              out_free;
    logic [svbs_pkg::GDIM_W-1:0]       grid_n;
    logic [svbs_pkg::VOX_W-1:0]        idx_sel;
    logic signed [12:0]                k_off;
    logic [10:0]                       k_mag;
    logic [11:0]                       n_scaled;
    logic [12:0]                       qn_x5;
    logic [12:0]                       qn_xd;
    logic [12:0]                       rn_full;
    logic [3:0]                        rn;
    logic [30:0]                       a_sel;
    logic [30:0]                       half_q;
    logic signed [31:0]                q_off;
    logic [30:0]                       sq_op;
    logic [31:0]                       mul_a;
    logic [31:0]                       mul_b;
    logic [63:0]                       mul_p;
    logic [63:0]                       recip_q;
    logic                              root_start;
    logic                              root_done;
    logic [31:0]                       root_len;
    logic signed [33:0]                dist_raw;
    logic signed [33:0]                dist_sat;
    logic signed [31:0]                q_neg;
    logic                              fg;

    svbs_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (root_start),
        .i_radicand (r_sum),
        .o_done     (root_done),
        .o_root     (root_len)
    );

    assign i_vox.ready = (r_state == svbs_pkg::S_IDLE);
    assign vox_xfer    = i_vox.valid && i_vox.ready;
    assign out_free    = !r_ovalid || o_smp.ready;
    assign o_smp.valid = r_ovalid;
    assign o_smp.data  = r_out;
    assign root_start  = (r_state == svbs_pkg::S_ROOT) && (r_cnt == 6'd0);

    // operand selection for the shared multiplier
    always_comb begin
        grid_n = (r_gdim > svbs_pkg::MAX_GRID_DIMS) ? svbs_pkg::MAX_GRID_DIMS : r_gdim;

        case (r_cnt[1:0])
            2'd0:    idx_sel = r_vox.voxel_x;
            2'd1:    idx_sel = r_vox.voxel_y;
            default: idx_sel = r_vox.voxel_z;
        endcase
        case (r_cnt[1:0])
            2'd0:    a_sel = r_a[0];
            2'd1:    a_sel = r_a[1];
            default: a_sel = r_a[2];
        endcase

        // doubled offset from the centre: 2*index + 1 - n
        k_off = $signed({2'b00, idx_sel, 1'b1}) - $signed({2'b00, grid_n});
        k_mag = k_off[12] ? 11'(-k_off) : k_off[10:0];

        // 2n for the radius, 3n for the half-extent
        n_scaled = (r_shape == svbs_pkg::SHAPE_BOX)
                 ? ({1'b0, grid_n} + {grid_n, 1'b0}) : {grid_n, 1'b0};

        // split n_scaled = d*qn + rn, d = 5 for the radius and 10 for the half-extent
        qn_x5   = {1'b0, r_qn, 2'b00} + {3'b000, r_qn};
        qn_xd   = (r_shape == svbs_pkg::SHAPE_BOX) ? {qn_x5[11:0], 1'b0} : qn_x5;
        rn_full = {1'b0, n_scaled} - qn_xd;
        rn      = rn_full[3:0];

        half_q = r_dq;
        q_off  = $signed({1'b0, a_sel}) - $signed({1'b0, half_q});
        if (r_shape == svbs_pkg::SHAPE_BOX) begin
            sq_op = (!q_off[31] && (q_off != 32'sd0)) ? q_off[30:0] : '0;
        end else begin
            sq_op = a_sel;
        end

        mul_a = '0;
        mul_b = '0;
        case (r_state)
            svbs_pkg::S_AXIS: begin
                mul_a = {11'd0, r_vsize};
                mul_b = {21'd0, k_mag};
            end
            svbs_pkg::S_EXT: begin
                // vs * d*qn is exact; only vs * rn needs the reciprocal
                case (r_cnt[1:0])
                    2'd0: begin
                        mul_a = {20'd0, n_scaled};
                        mul_b = {8'd0, svbs_pkg::RECIP_DIV5};
                    end
                    2'd1: begin
                        mul_a = {11'd0, r_vsize};
                        mul_b = {22'd0, r_qn};
                    end
                    2'd2: begin
                        mul_a = {11'd0, r_vsize};
                        mul_b = {28'd0, rn};
                    end
                    default: begin
                        mul_a = {7'd0, r_part};
                        mul_b = {8'd0, svbs_pkg::RECIP_DIV5};
                    end
                endcase
            end
            svbs_pkg::S_SQ: begin
                mul_a = {1'b0, sq_op};
                mul_b = {1'b0, sq_op};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;

        recip_q = (r_shape == svbs_pkg::SHAPE_BOX) ? (mul_p >> svbs_pkg::RECIP_SHIFT_BOX)
                                                   : (mul_p >> svbs_pkg::RECIP_SHIFT_SPHERE);

        // final distance and saturation
        q_neg = r_qmax[31] ? r_qmax : 32'sd0;
        if (r_shape == svbs_pkg::SHAPE_BOX) begin
            dist_raw = $signed({2'b00, root_len}) + 34'(q_neg);
        end else begin
            dist_raw = $signed({2'b00, root_len}) - $signed({3'b000, r_dq});
        end
        if (dist_raw > svbs_pkg::BG_Q16) begin
            dist_sat = svbs_pkg::BG_Q16;
        end else if (dist_raw < -svbs_pkg::BG_Q16) begin
            dist_sat = -svbs_pkg::BG_Q16;
        end else begin
            dist_sat = dist_raw;
        end
        fg = (dist_sat != svbs_pkg::BG_Q16);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            svbs_pkg::S_IDLE: if (vox_xfer) n_state = svbs_pkg::S_AXIS;
            svbs_pkg::S_AXIS: if (r_cnt == 6'd2) n_state = svbs_pkg::S_EXT;
            svbs_pkg::S_EXT:  if (r_cnt == 6'd3) n_state = svbs_pkg::S_SQ;
            svbs_pkg::S_SQ:   if (r_cnt == 6'd3) n_state = svbs_pkg::S_ROOT;
            svbs_pkg::S_ROOT: if (root_done) n_state = svbs_pkg::S_FIN;
            svbs_pkg::S_FIN:  if (out_free) n_state = svbs_pkg::S_IDLE;
            default:          n_state = svbs_pkg::S_IDLE;
        endcase

        if (n_state != r_state) begin
            n_cnt = '0;
        end else if (r_state == svbs_pkg::S_ROOT) begin
            n_cnt = 6'd1;
        end else begin
            n_cnt = r_cnt + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= svbs_pkg::S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_saw    <= 1'b0;
            r_shape  <= svbs_pkg::SHAPE_SPHERE;
            r_vsize  <= svbs_pkg::VSIZE_RESET;
            r_gdim   <= svbs_pkg::GDIM_RESET;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    svbs_pkg::CFG_SHAPE: r_shape <= i_cfg_data[0];
                    svbs_pkg::CFG_VSIZE: r_vsize <= i_cfg_data[svbs_pkg::VSIZE_W-1:0];
                    svbs_pkg::CFG_GDIM:  r_gdim  <= i_cfg_data[svbs_pkg::GDIM_W-1:0];
                    default: ;
                endcase
            end

            if (r_state == svbs_pkg::S_FIN && out_free) begin
                r_ovalid <= 1'b1;
                r_saw    <= r_vox.brick_last ? 1'b0 : (r_saw | fg);
            end else if (o_smp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            svbs_pkg::S_IDLE: begin
                if (vox_xfer) r_vox <= i_vox.data;
            end
            svbs_pkg::S_AXIS: begin
                r_a[r_cnt[1:0]] <= mul_p[31:1];
            end
            svbs_pkg::S_EXT: begin
                case (r_cnt[1:0])
                    2'd0:    r_qn   <= recip_q[9:0];
                    2'd1:    r_dq   <= mul_p[30:0];
                    2'd2:    r_part <= mul_p[24:0];
                    default: r_dq   <= r_dq + recip_q[30:0];
                endcase
            end
            svbs_pkg::S_SQ: begin
                // product of one axis, accumulate the one before
                r_prod <= mul_p;
                r_sum  <= (r_cnt == 6'd0) ? 64'd0 : (r_sum + r_prod);
                if (r_cnt == 6'd0) begin
                    r_qmax <= q_off;
                end else if (r_cnt != 6'd3 && q_off > r_qmax) begin
                    r_qmax <= q_off;
                end
            end
            svbs_pkg::S_FIN: begin
                if (out_free) begin
                    r_out.distance_q16 <= dist_sat[svbs_pkg::DIST_W-1:0];
                    r_out.brick_end    <= r_vox.brick_last;
                    r_out.brick_active <= r_vox.brick_last & (r_saw | fg);
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/svbs_isqrt.sv -----
// Iterative integer square root of a 64-bit value, one result bit per cycle.
module svbs_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic [63:0] n_trial;
    logic        n_take;

    always_comb begin
        n_trial = r_r + r_bit;
        n_take  = (r_v >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == svbs_pkg::ROOT_LAST_STEP);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == svbs_pkg::ROOT_LAST_STEP) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_radicand;
            r_r   <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (n_take) begin
                r_v <= r_v - n_trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[31:0];

endmodule

// ----- rtl/svbs_checker.sv -----
// Port-level checks of the SDF voxel brick sampler, bound to the top level.
module svbs_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  svbs_pkg::t_sample  i_out_data
);

    localparam logic signed [svbs_pkg::DIST_W-1:0] DIST_MAX = 27'sd65536000;

    // hold a stalled sample
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("sample dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("stalled sample changed");

    // one item at a time: no transfer in the cycle after a transfer
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after a transfer");

    a_active_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.brick_end |-> !i_out_data.brick_active)
        else $error("brick_active outside brick end");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.distance_q16 <= DIST_MAX)
                     && (i_out_data.distance_q16 >= -DIST_MAX))
        else $error("distance beyond saturation limit");

endmodule

bind sdf_voxel_brick_sampler_unit svbs_checker u_svbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vox.valid),
    .i_in_ready  (i_vox.ready),
    .i_out_valid (o_smp.valid),
    .i_out_ready (o_smp.ready),
    .i_out_data  (o_smp.data)
);

// ----- tb/tb_sdf_voxel_brick_sampler_unit.sv -----
// Self-checking testbench for the SDF voxel brick sampler with shape and grid sweeps.
module tb_sdf_voxel_brick_sampler_unit;

    localparam int     CYCLE_LIMIT = 1000000;
    localparam int     HOLD_CYCLES = 300;
    localparam int     CALM_FROM   = 500;
    localparam int     CALM_TO     = 650;
    localparam int     SETTLE      = 100;
    localparam longint SAT_Q16     = longint'(svbs_pkg::BG_Q16);
    localparam logic [svbs_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic                           cfg_we;
    logic [svbs_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [svbs_pkg::CFG_W-1:0]     cfg_data;

    svbs_voxel_if  vox_ch ();
    svbs_sample_if smp_ch ();

    sdf_voxel_brick_sampler_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vox      (vox_ch),
        .o_smp      (smp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Mirror of the block's registers and brick flag
    svbs_pkg::t_shape             shape_cfg;
    logic [svbs_pkg::VSIZE_W-1:0] vsize_cfg;
    logic [svbs_pkg::GDIM_W-1:0]  gdim_cfg;
    logic                         saw_fg;

    svbs_pkg::t_voxel  voxel_queue[$];
    svbs_pkg::t_sample expected_samples[$];

    int voxels_sent;
    int samples_seen;
    int mismatch_count;
    int bricks_closed;
    int bricks_active;
    int cycle_count;
    int gap_left;
    int stall_left;
    bit hold_armed;
    bit hold_done;

    always #5 i_clk = ~i_clk;

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    // Q16.16 offset of a voxel centre from the grid centre along one axis
    function automatic longint unsigned half_offset(
        input logic [svbs_pkg::VOX_W-1:0] idx,
        input longint unsigned n,
        input longint unsigned vs
    );
        longint k;
        k = 2 * longint'(idx) + 1 - longint'(n);
        return (vs * longint'(k < 0 ? -k : k)) >> 1;
    endfunction

    function automatic svbs_pkg::t_sample predict_sample(input svbs_pkg::t_voxel v);
        longint unsigned   n;
        longint unsigned   vs;
        longint unsigned   ext;
        longint unsigned   sum;
        longint unsigned   off [3];
        longint            half;
        longint            q;
        longint            qmax;
        longint            d;
        svbs_pkg::t_sample s;
        n   = (gdim_cfg > svbs_pkg::MAX_GRID_DIMS) ? svbs_pkg::MAX_GRID_DIMS : gdim_cfg;
        vs  = vsize_cfg;
        ext = n * vs;
        sum = 0;
        off[0] = half_offset(v.voxel_x, n, vs);
        off[1] = half_offset(v.voxel_y, n, vs);
        off[2] = half_offset(v.voxel_z, n, vs);
        if (shape_cfg == svbs_pkg::SHAPE_SPHERE) begin
            for (int i = 0; i < 3; i++) sum += off[i] * off[i];
            d = longint'(root_floor(sum)) - longint'(ext * 2 / 5);
        end else begin
            half = longint'(ext * 3 / 10);
            qmax = -(longint'(1) <<< 62);
            for (int i = 0; i < 3; i++) begin
                q = longint'(off[i]) - half;
                if (q > qmax) qmax = q;
                if (q > 0) sum += longint'(q * q);
            end
            d = longint'(root_floor(sum)) + ((qmax < 0) ? qmax : 0);
        end
        if (d > SAT_Q16) d = SAT_Q16;
        else if (d < -SAT_Q16) d = -SAT_Q16;
        if (d != SAT_Q16) saw_fg = 1'b1;
        s.distance_q16 = d[svbs_pkg::DIST_W-1:0];
        s.brick_end    = v.brick_last;
        s.brick_active = v.brick_last & saw_fg;
        if (v.brick_last) saw_fg = 1'b0;
        return s;
    endfunction

    // Track register writes exactly as the block sees them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shape_cfg = svbs_pkg::SHAPE_SPHERE;
            vsize_cfg = svbs_pkg::VSIZE_RESET;
            gdim_cfg  = svbs_pkg::GDIM_RESET;
        end else if (cfg_we) begin
            case (cfg_idx)
                svbs_pkg::CFG_SHAPE: shape_cfg = svbs_pkg::t_shape'(cfg_data[0]);
                svbs_pkg::CFG_VSIZE: vsize_cfg = cfg_data[svbs_pkg::VSIZE_W-1:0];
                svbs_pkg::CFG_GDIM:  gdim_cfg  = cfg_data[svbs_pkg::GDIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Voxel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vox_ch.valid <= 1'b0;
            gap_left = 0;
            saw_fg   = 1'b0;
        end else begin
            if (vox_ch.valid && vox_ch.ready) begin
                expected_samples.insert(expected_samples.size(), predict_sample(vox_ch.data));
                voxels_sent++;
            end
            // hold the offered item until it transfers
            if (!vox_ch.valid || vox_ch.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    vox_ch.valid <= 1'b0;
                end else if (voxel_queue.size() == 0) begin
                    vox_ch.valid <= 1'b0;
                end else if (!(voxels_sent >= CALM_FROM && voxels_sent < CALM_TO)
                             && $urandom_range(99) < 3) begin
                    gap_left = $urandom_range(1, 3);
                    vox_ch.valid <= 1'b0;
                end else begin
                    vox_ch.valid <= 1'b1;
                    vox_ch.data  <= voxel_queue.pop_front();
                end
            end
        end
    end

    // Sample monitor and checker
    always @(posedge i_clk) begin
        svbs_pkg::t_sample want;
        if (!i_rst_n) begin
            smp_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (smp_ch.valid && smp_ch.ready) begin
                samples_seen++;
                if (smp_ch.data.brick_end) begin
                    bricks_closed++;
                    if (smp_ch.data.brick_active) bricks_active++;
                end
                if (expected_samples.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: sample %0d unexpected: dist=%0d end=%b act=%b",
                                 samples_seen, $signed(smp_ch.data.distance_q16),
                                 smp_ch.data.brick_end, smp_ch.data.brick_active);
                end else begin
                    want = expected_samples.pop_front();
                    if (want.distance_q16 !== smp_ch.data.distance_q16
                        || want.brick_end !== smp_ch.data.brick_end
                        || want.brick_active !== smp_ch.data.brick_active) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("ERROR: sample %0d exp dist=%0d end=%b act=%b",
                                     samples_seen, $signed(want.distance_q16),
                                     want.brick_end, want.brick_active);
                            $display("       got dist=%0d end=%b act=%b",
                                     $signed(smp_ch.data.distance_q16),
                                     smp_ch.data.brick_end, smp_ch.data.brick_active);
                        end
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                smp_ch.ready <= 1'b0;
            end else if (hold_armed && !hold_done) begin
                // long hold-off: let the block back up into its input
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
                smp_ch.ready <= 1'b0;
            end else if (!(samples_seen >= CALM_FROM && samples_seen < CALM_TO)
                         && $urandom_range(999) < 3) begin
                stall_left = $urandom_range(1, 60);
                smp_ch.ready <= 1'b0;
            end else begin
                smp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ERROR: timeout with %0d samples still expected", expected_samples.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(input logic [svbs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [svbs_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (voxel_queue.size() != 0 || vox_ch.valid || expected_samples.size() != 0);
    endtask

    task automatic push_voxel(input int x, input int y, input int z, input bit last);
        svbs_pkg::t_voxel v;
        v.voxel_x    = x[svbs_pkg::VOX_W-1:0];
        v.voxel_y    = y[svbs_pkg::VOX_W-1:0];
        v.voxel_z    = z[svbs_pkg::VOX_W-1:0];
        v.brick_last = last;
        voxel_queue.insert(voxel_queue.size(), v);
    endtask

    // Bricks of nearby voxels around random points of the grid, with some stray voxels and broken framing
    task automatic queue_bricks(input int span, input int count);
        int               left;
        int               len;
        int               k;
        int               bx;
        int               by;
        int               bz;
        svbs_pkg::t_voxel v;
        left = count;
        while (left > 0) begin
            len = $urandom_range(1, 12);
            if (len > left) len = left;
            bx = $urandom_range(0, span - 1);
            by = $urandom_range(0, span - 1);
            bz = $urandom_range(0, span - 1);
            for (k = 0; k < len; k++) begin
                if ($urandom_range(9) == 0) begin
                    v.voxel_x = svbs_pkg::VOX_W'($urandom_range(0, 1023));
                    v.voxel_y = svbs_pkg::VOX_W'($urandom_range(0, 1023));
                    v.voxel_z = svbs_pkg::VOX_W'($urandom_range(0, 1023));
                end else begin
                    v.voxel_x = svbs_pkg::VOX_W'(bx + $urandom_range(0, 3));
                    v.voxel_y = svbs_pkg::VOX_W'(by + $urandom_range(0, 3));
                    v.voxel_z = svbs_pkg::VOX_W'(bz + $urandom_range(0, 3));
                end
                v.brick_last = (k == len - 1);
                if ($urandom_range(19) == 0) v.brick_last = ~v.brick_last;
                voxel_queue.insert(voxel_queue.size(), v);
            end
            left -= len;
        end
    endtask

    task automatic run_phase(input svbs_pkg::t_shape sh,
                             input logic [svbs_pkg::VSIZE_W-1:0] vs,
                             input logic [svbs_pkg::GDIM_W-1:0] gd,
                             input int count, input bit arm_hold);
        int span;
        write_reg(svbs_pkg::CFG_SHAPE, sh);
        write_reg(svbs_pkg::CFG_VSIZE, vs);
        write_reg(svbs_pkg::CFG_GDIM, gd);
        span = (gd == 0) ? 1
             : ((gd > svbs_pkg::MAX_GRID_DIMS) ? svbs_pkg::MAX_GRID_DIMS : gd);
        @(negedge i_clk);
        queue_bricks(span, count);
        if (arm_hold) hold_armed = 1'b1;
        wait_drained();
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        vox_ch.valid   = 1'b0;
        vox_ch.data    = '0;
        smp_ch.ready   = 1'b0;
        voxels_sent    = 0;
        samples_seen   = 0;
        mismatch_count = 0;
        bricks_closed  = 0;
        bricks_active  = 0;
        cycle_count    = 0;
        hold_armed     = 1'b0;
        hold_done      = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: sphere, 1 mm voxels, 128 per axis
        @(negedge i_clk);
        push_voxel(0, 0, 0, 0);
        push_voxel(1023, 1023, 1023, 1);
        push_voxel(1023, 1023, 1023, 0);
        push_voxel(1023, 1023, 0, 1);
        push_voxel(63, 64, 63, 0);
        push_voxel(64, 63, 64, 1);
        push_voxel(1023, 0, 0, 1);
        push_voxel(0, 1023, 512, 0);
        push_voxel(511, 512, 1023, 1);
        wait_drained();

        // Box, with stray bits above the widths of the shape and grid registers
        write_reg(svbs_pkg::CFG_SHAPE, 21'h0AAAAB);
        write_reg(svbs_pkg::CFG_GDIM, 21'h1FF080);
        @(negedge i_clk);
        push_voxel(63, 63, 63, 0);
        push_voxel(0, 0, 0, 0);
        push_voxel(1023, 1023, 1023, 1);
        push_voxel(1023, 1023, 1023, 0);
        push_voxel(1023, 1023, 1023, 1);
        push_voxel(100, 64, 64, 1);
        push_voxel(100, 100, 64, 0);
        push_voxel(64, 100, 100, 1);
        wait_drained();

        run_phase(svbs_pkg::SHAPE_SPHERE, 21'd65536, 11'd128, 110, 1'b1);
        run_phase(svbs_pkg::SHAPE_BOX, 21'd65536, 11'd128, 110, 1'b0);
        run_phase(svbs_pkg::SHAPE_SPHERE, 21'd1, 11'd1024, 90, 1'b0);
        run_phase(svbs_pkg::SHAPE_BOX, 21'd1048576, 11'd1, 70, 1'b0);
        run_phase(svbs_pkg::SHAPE_SPHERE, 21'd1048576, 11'd1024, 70, 1'b0);
        run_phase(svbs_pkg::SHAPE_BOX, 21'd0, 11'd0, 50, 1'b0);
        run_phase(svbs_pkg::SHAPE_SPHERE, 21'h1FFFFF, 11'd2047, 50, 1'b0);
        run_phase(svbs_pkg::SHAPE_BOX, 21'd20000, 11'd300, 110, 1'b0);
        // unused index must leave the registers alone
        write_reg(CFG_SPARE, '1);
        repeat (3)
            run_phase(svbs_pkg::t_shape'($urandom_range(0, 1)),
                      svbs_pkg::VSIZE_W'($urandom_range(1, 1048576)),
                      svbs_pkg::GDIM_W'($urandom_range(1, 1024)), 100, 1'b0);

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        $display("Checked %0d voxel samples, %0d bricks closed (%0d active), sphere and box,",
                 samples_seen, bricks_closed, bricks_active);
        $display("over grid and voxel sizes from zero to beyond range; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && expected_samples.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
